[rtl/fixed_partition_fit_allocator_top_defines.svh]
// assertion macros for the partition fit allocator
// used by modules that check their own control logic; expects clk and rst_n in scope
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define FPFA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpfa check failed");

// next-cycle implication
`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpfa check failed");

`endif

[rtl/fpfa_pkg.sv]
// shared types and constants of the partition fit allocator
// no dependencies; the interface, top, datapath and controller files refer to it by scoped names
`default_nettype none

package fpfa_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_W     = 16;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(NUM_BLOCKS + 1);

    // fixed field widths of the channels
    localparam int ACTION_W = 2;
    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int LEFT_W   = 16;
    localparam int POLICY_W = 2;
    localparam int ACTIVE_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int CMP_W = (ACTIVE_W > CNT_W) ? ((ACTIVE_W > SLOT_W) ? ACTIVE_W : SLOT_W)
                                             : ((CNT_W > SLOT_W) ? CNT_W : SLOT_W);

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_ALLOC = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/fpfa_if.sv]
// handshake channels of the partition fit allocator: request, result, config write
// depends on fpfa_pkg for field widths
`default_nettype none

interface fpfa_req_if;
    logic                          valid;
    logic                          ready;
    logic [fpfa_pkg::ACTION_W-1:0] action;
    logic [fpfa_pkg::SLOT_W-1:0]   slot;
    logic [fpfa_pkg::AMOUNT_W-1:0] amount;

    modport source (output valid, action, slot, amount, input ready);
    modport sink   (input valid, action, slot, amount, output ready);
endinterface

interface fpfa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        granted;
    logic [fpfa_pkg::SLOT_W-1:0] chosen_slot;
    logic [fpfa_pkg::LEFT_W-1:0] leftover;

    modport source (output valid, granted, chosen_slot, leftover, input ready);
    modport sink   (input valid, granted, chosen_slot, leftover, output ready);
endinterface

interface fpfa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [fpfa_pkg::CFG_IDX_W-1:0]  index;
    logic [fpfa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/fixed_partition_fit_allocator_top.sv]
// Fixed-partition fit allocator, top level.
// Channels: req (action, slot, amount), rsp (granted, chosen_slot, leftover),
// cfg (index, data) with register 0 policy and register 1 active_blocks.
// A load beat writes one partition size and clears its used mark (only for a
// slot below the active count); a clear beat clears all used marks; both take
// effect at the accepting edge, and req is ready again on the next cycle, so
// they run at one beat per cycle. An allocate beat scans the active partitions
// one per cycle through a single compare unit (n = active count, at most 16),
// then writes the output register from its result state; an empty table goes
// straight to the result state. req is ready only while the block is idle.
// Results sit in an output register; loads and clears keep flowing while it
// waits, but a following allocate holds in its result step until rsp is taken.
// Reset clears all sizes and used marks, sets first fit and 16 active
// partitions. cfg is always ready; write it only while the block is idle.
`default_nettype none

module fixed_partition_fit_allocator_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    fpfa_req_if.sink    req,
    fpfa_rsp_if.source  rsp,
    fpfa_cfg_if.sink    cfg
);

    fpfa_pkg::cmd_t    cmd;
    fpfa_pkg::status_t status;

    assign cfg.ready = 1'b1;

    fpfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .action    (req.action),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    fpfa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .slot        (req.slot),
        .amount      (req.amount),
        .cfg_valid   (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp.valid),
        .granted     (rsp.granted),
        .chosen_slot (rsp.chosen_slot),
        .leftover    (rsp.leftover)
    );

endmodule

`default_nettype wire

[rtl/fpfa_dp.sv]
// datapath: partition table, used marks, config registers, scan unit and result register
// depends on fpfa_pkg; driven by commands from fpfa_ctrl
`default_nettype none

module fpfa_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire fpfa_pkg::cmd_t                    cmd,
    output fpfa_pkg::status_t                      status,
    input  wire logic [fpfa_pkg::SLOT_W-1:0]       slot,
    input  wire logic [fpfa_pkg::AMOUNT_W-1:0]     amount,
    input  wire logic                              cfg_valid,
    input  wire logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fpfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              rsp_ready,
    output logic                                   rsp_valid,
    output logic                                   granted,
    output logic [fpfa_pkg::SLOT_W-1:0]            chosen_slot,
    output logic [fpfa_pkg::LEFT_W-1:0]            leftover
);

    logic [fpfa_pkg::SIZE_W-1:0]   size_reg  [fpfa_pkg::NUM_BLOCKS];
    logic [fpfa_pkg::SIZE_W-1:0]   size_next [fpfa_pkg::NUM_BLOCKS];
    logic [fpfa_pkg::NUM_BLOCKS-1:0] used_reg, used_next;
    logic [fpfa_pkg::POLICY_W-1:0] policy_reg, policy_next;
    logic [fpfa_pkg::ACTIVE_W-1:0] active_reg, active_next;
    logic [fpfa_pkg::SIZE_W-1:0]   req_reg, req_next;
    logic [fpfa_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic                          found_reg, found_next;
    logic [fpfa_pkg::IDX_W-1:0]    pick_reg, pick_next;
    logic [fpfa_pkg::SIZE_W-1:0]   best_reg, best_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_granted_reg, out_granted_next;
    logic [fpfa_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;
    logic [fpfa_pkg::LEFT_W-1:0]   out_left_reg, out_left_next;

    logic [fpfa_pkg::CNT_W-1:0]  n_act;
    logic [fpfa_pkg::IDX_W-1:0]  cur_idx;
    logic [fpfa_pkg::IDX_W-1:0]  load_idx;
    logic [fpfa_pkg::SIZE_W-1:0] cur_size;
    logic                        cur_fit;
    logic                        cur_better;
    logic                        load_ok;

    // active count, saturated at the table depth
    always_comb
    begin
        if (fpfa_pkg::CMP_W'(active_reg) > fpfa_pkg::CMP_W'(fpfa_pkg::NUM_BLOCKS))
            n_act = fpfa_pkg::CNT_W'(fpfa_pkg::NUM_BLOCKS);
        else
            n_act = fpfa_pkg::CNT_W'(active_reg);
    end

    assign cur_idx  = idx_reg[fpfa_pkg::IDX_W-1:0];
    assign load_idx = fpfa_pkg::IDX_W'(slot);
    assign load_ok  = fpfa_pkg::CMP_W'(slot) < fpfa_pkg::CMP_W'(n_act);
    assign cur_size = size_reg[cur_idx];
    assign cur_fit  = !used_reg[cur_idx] && (cur_size >= req_reg);

    // later entries win only if strictly better, so ties keep the lower index
    assign cur_better = !found_reg
                     || ((policy_reg == fpfa_pkg::POL_BEST)  && (cur_size < best_reg))
                     || ((policy_reg == fpfa_pkg::POL_WORST) && (cur_size > best_reg));

    assign status.empty     = (n_act == '0);
    assign status.scan_last = (idx_reg == (n_act - fpfa_pkg::CNT_W'(1)));
    assign status.out_free  = !out_valid_reg || rsp_ready;

    always_comb
    begin
        policy_next = policy_reg;
        active_next = active_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                fpfa_pkg::REG_POLICY: policy_next = cfg_data[fpfa_pkg::POLICY_W-1:0];
                fpfa_pkg::REG_ACTIVE: active_next = cfg_data[fpfa_pkg::ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        size_next = size_reg;
        used_next = used_reg;
        if (cmd.load && load_ok)
        begin
            size_next[load_idx] = fpfa_pkg::SIZE_W'(amount);
            used_next[load_idx] = 1'b0;
        end
        if (cmd.clear)
            used_next = '0;
        if (cmd.finish && found_reg)
            used_next[pick_reg] = 1'b1;
    end

    always_comb
    begin
        req_next   = req_reg;
        idx_next   = idx_reg;
        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (cmd.start)
        begin
            req_next   = fpfa_pkg::SIZE_W'(amount);
            idx_next   = '0;
            found_next = 1'b0;
            pick_next  = '0;
            best_next  = '0;
        end
        else if (cmd.step)
        begin
            if (cur_fit && cur_better)
            begin
                found_next = 1'b1;
                pick_next  = cur_idx;
                best_next  = cur_size;
            end
            idx_next = idx_reg + fpfa_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_granted_next = out_granted_reg;
        out_slot_next    = out_slot_reg;
        out_left_next    = out_left_reg;
        if (cmd.finish)
        begin
            out_valid_next   = 1'b1;
            out_granted_next = found_reg;
            out_slot_next    = found_reg ? fpfa_pkg::SLOT_W'(pick_reg) : '0;
            out_left_next    = found_reg ? fpfa_pkg::LEFT_W'(best_reg - req_reg) : '0;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fpfa_pkg::NUM_BLOCKS; i++)
                size_reg[i] <= '0;
            used_reg      <= '0;
            policy_reg    <= fpfa_pkg::POL_FIRST;
            active_reg    <= fpfa_pkg::ACTIVE_W'(fpfa_pkg::NUM_BLOCKS);
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            size_reg      <= size_next;
            used_reg      <= used_next;
            policy_reg    <= policy_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        pick_reg        <= pick_next;
        best_reg        <= best_next;
        out_granted_reg <= out_granted_next;
        out_slot_reg    <= out_slot_next;
        out_left_reg    <= out_left_next;
    end

    assign rsp_valid   = out_valid_reg;
    assign granted     = out_granted_reg;
    assign chosen_slot = out_slot_reg;
    assign leftover    = out_left_reg;

endmodule

`default_nettype wire

[rtl/fpfa_ctrl.sv]
// controller: accepts request beats, sequences the table scan and the result write
// depends on fpfa_pkg and the assertion macro header
`default_nettype none
`include "fixed_partition_fit_allocator_top_defines.svh"

module fpfa_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    input  wire logic [fpfa_pkg::ACTION_W-1:0]   action,
    output logic                                 req_ready,
    input  wire fpfa_pkg::status_t               status,
    output fpfa_pkg::cmd_t                       cmd
);

    fpfa_pkg::state_t state_reg, state_next;
    logic             accept;

    assign req_ready = (state_reg == fpfa_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            fpfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (action)
                        fpfa_pkg::ACT_LOAD:  cmd.load  = 1'b1;
                        fpfa_pkg::ACT_CLEAR: cmd.clear = 1'b1;
                        fpfa_pkg::ACT_ALLOC:
                        begin
                            cmd.start  = 1'b1;
                            // empty table goes straight to a not-granted result
                            state_next = status.empty ? fpfa_pkg::ST_RESULT
                                                      : fpfa_pkg::ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            fpfa_pkg::ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_last)
                    state_next = fpfa_pkg::ST_RESULT;
            end
            fpfa_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = fpfa_pkg::ST_IDLE;
                end
            end
            default: state_next = fpfa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fpfa_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    `FPFA_ASSERT_NOW(a_finish_needs_room, cmd.finish, status.out_free)
    `FPFA_ASSERT_NEXT(a_alloc_enters_work, accept && (action == fpfa_pkg::ACT_ALLOC),
        (state_reg == fpfa_pkg::ST_SCAN) || (state_reg == fpfa_pkg::ST_RESULT))
    `FPFA_ASSERT_NEXT(a_scan_holds, (state_reg == fpfa_pkg::ST_SCAN) && !status.scan_last,
        state_reg == fpfa_pkg::ST_SCAN)
    `FPFA_ASSERT_NOW(a_one_cmd, 1'b1, $onehot0(cmd))

endmodule

`default_nettype wire
